[rtl/core/smf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_pkg: shared types for the sequence mode finder
// Cell state, ring stream and cell operation codes used by the cell chain.
// ----------------------------------------------------------------------------
package smf_pkg;

	localparam int VAL_W   = 32;
	localparam int TALLY_W = 7;

	// operation broadcast to every cell of the chain
	typedef enum logic [2:0] {
		OP_HOLD  = 3'd0,
		OP_LOAD  = 3'd1,
		OP_INIT  = 3'd2,
		OP_COUNT = 3'd3,
		OP_MAX   = 3'd4,
		OP_REAR  = 3'd5,
		OP_DRAIN = 3'd6
	} cell_op_t;

	// state held by one cell
	typedef struct packed {
		logic [VAL_W-1:0]   val;
		logic [TALLY_W-1:0] tally;
		logic               head;
		logic               rear;
		logic [TALLY_W-1:0] mx;
	} cell_t;

	// one element of the rotating compare stream
	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic             vld;
		logic             wrap;
	} stream_t;

endpackage
`default_nettype wire

[rtl/core/smf_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_cell: one cell of the value chain
// Holds one stored value, its tally, head mark and reduction flags, plus one
// slot of the rotating compare stream.
// ----------------------------------------------------------------------------
module smf_cell (
	input  wire logic                 clk,
	input  wire smf_pkg::cell_op_t    op,
	input  wire logic [31:0]          newer_val,
	input  wire smf_pkg::cell_t       older,
	input  wire logic                 older_mode,
	input  wire smf_pkg::stream_t     strm_in,
	input  wire logic                 occupied,
	input  wire logic [6:0]           best,
	output smf_pkg::cell_t            st,
	output smf_pkg::stream_t          strm,
	output logic                      mode
);
	import smf_pkg::*;

	cell_t              st_q;
	stream_t            strm_q;
	logic [TALLY_W-1:0] own_t;
	logic               hit;

	assign own_t = st_q.head ? st_q.tally : '0;
	assign hit   = strm_q.vld && (strm_q.val == st_q.val);
	assign mode  = st_q.head && (st_q.tally == best);
	assign st    = st_q;
	assign strm  = strm_q;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				st_q.val <= newer_val;
			end
			OP_INIT: begin
				strm_q.val  <= st_q.val;
				strm_q.vld  <= occupied;
				strm_q.wrap <= 1'b0;
				st_q.head   <= occupied;
				st_q.tally  <= '0;
				st_q.mx     <= '0;
				st_q.rear   <= 1'b0;
			end
			OP_COUNT: begin
				// advance the ring; a match from a newer entry drops the head mark
				strm_q <= strm_in;
				if (hit && strm_q.wrap) begin
					st_q.head <= 1'b0;
				end else if (hit) begin
					st_q.tally <= st_q.tally + 1'b1;
				end
			end
			OP_MAX: begin
				st_q.mx <= (older.mx > own_t) ? older.mx : own_t;
			end
			OP_REAR: begin
				st_q.rear <= older.rear | older_mode;
			end
			OP_DRAIN: begin
				st_q.val   <= older.val;
				st_q.tally <= older.tally;
				st_q.head  <= older.head;
				st_q.rear  <= older.rear;
			end
			default: begin
				st_q <= st_q;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/sequence_mode_finder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequence_mode_finder: statistical mode with ties over a loaded set
// Loads signed values newest first into a chain of cells; an end item counts
// the occurrences of every distinct value and emits each most frequent value.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | sink      | in_valid, in_stall | sample_value, end_of_set
//  out     | source    | out_valid,out_stall| mode_value, mode_count,
//          |           |                    | set_empty, values_dropped,
//          |           |                    | last_result
//
//  A new value may follow every cycle while in_stall is low.
//  An end transfer with a non-empty set runs the ring count, the max
//  reduction and the trailing-mode reduction, then drains the cells until
//  the oldest mode leaves cell 0, holding each mode in cell 0 while
//  out_stall keeps the output register full.
//  An empty set gives its single result as soon as the output register frees.
//  Reset clears control only; stored values are never read before written.
//  in_stall is high while a search or its results are in flight.
//
module sequence_mode_finder #(
	parameter int STORE_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] sample_value,
	input  wire logic               end_of_set,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      mode_value,
	output logic [6:0]              mode_count,
	output logic                    set_empty,
	output logic                    values_dropped,
	output logic                    last_result
);
	import smf_pkg::*;

	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
	localparam int STEP_W = $clog2(STORE_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_COUNT = 6'b000010,
		S_MAX   = 6'b000100,
		S_REAR  = 6'b001000,
		S_DRAIN = 6'b010000,
		S_EMPTY = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    fill_q;
	logic [STEP_W-1:0]   step_q, step_d;
	logic                ovf_q, run_drop_q;
	logic                out_valid_q;
	logic signed [31:0]  mode_value_q;
	logic [6:0]          mode_count_q;
	logic                set_empty_q, last_result_q, values_dropped_q;

	cell_op_t            op;
	cell_t               cell_st   [STORE_DEPTH];
	stream_t             cell_strm [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] cell_mode;
	logic [TALLY_W-1:0]  best;

	logic in_xfer, full, step_last, phase, out_free, load_mode, load_empty, end_xfer;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign full      = (fill_q == CNT_W'(STORE_DEPTH));
	assign step_last = (step_q == STEP_W'(STORE_DEPTH - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign best      = cell_st[0].mx;   // max settles in cell 0 after the max phase
	assign phase     = (state_q == S_COUNT) || (state_q == S_MAX) || (state_q == S_REAR);
	assign step_d    = (phase && !step_last) ? step_q + 1'b1 : '0;
	assign end_xfer  = in_xfer && end_of_set;

	// --- sequencer --------------------------------------------------------
	always_comb begin
		state_d    = state_q;
		op         = OP_HOLD;
		load_mode  = 1'b0;
		load_empty = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && end_of_set) begin
					if (fill_q == '0) begin
						state_d = S_EMPTY;
					end else begin
						op      = OP_INIT;
						state_d = S_COUNT;
					end
				end else if (in_xfer && !full) begin
					op = OP_LOAD;
				end
			end
			S_COUNT: begin
				op = OP_COUNT;
				if (step_last) state_d = S_MAX;
			end
			S_MAX: begin
				op = OP_MAX;
				if (step_last) state_d = S_REAR;
			end
			S_REAR: begin
				op = OP_REAR;
				if (step_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				// shift past non-modes; hold a mode until the output frees
				if (cell_mode[0]) begin
					if (out_free) begin
						op        = OP_DRAIN;
						load_mode = 1'b1;
						if (!cell_st[0].rear) state_d = S_IDLE;
					end
				end else begin
					op = OP_DRAIN;
				end
			end
			S_EMPTY: begin
				if (out_free) begin
					load_empty = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			run_drop_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (end_xfer) begin
				// latch the drop flag for this run, then start a fresh set
				run_drop_q <= ovf_q;
				ovf_q      <= 1'b0;
				fill_q     <= '0;
			end else if (in_xfer && full) begin
				ovf_q <= 1'b1;
			end else if (in_xfer) begin
				fill_q <= fill_q + 1'b1;
			end
			if (load_mode || load_empty) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load_mode) begin
			mode_value_q     <= $signed(cell_st[0].val);
			mode_count_q     <= cell_st[0].tally;
			set_empty_q      <= 1'b0;
			values_dropped_q <= run_drop_q;
			last_result_q    <= !cell_st[0].rear;
		end else if (load_empty) begin
			mode_value_q     <= '0;
			mode_count_q     <= '0;
			set_empty_q      <= 1'b1;
			values_dropped_q <= run_drop_q;
			last_result_q    <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign mode_value     = mode_value_q;
	assign mode_count     = mode_count_q;
	assign set_empty      = set_empty_q;
	assign values_dropped = values_dropped_q;
	assign last_result    = last_result_q;

	// --- cell chain: cell 0 holds the newest value ------------------------
	for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
		cell_t   older;
		logic    older_mode;
		stream_t strm_in;
		logic    occupied;

		assign occupied = (CNT_W'(k) < fill_q);

		if (k == STORE_DEPTH - 1) begin : g_tail
			// the ring closes here; elements passing cell 0 are newer ones
			assign older      = '0;
			assign older_mode = 1'b0;
			assign strm_in    = '{val: cell_strm[0].val, vld: cell_strm[0].vld, wrap: 1'b1};
		end else begin : g_body
			assign older      = cell_st[k+1];
			assign older_mode = cell_mode[k+1];
			assign strm_in    = cell_strm[k+1];
		end

		smf_cell u_cell (
			.clk        (clk),
			.op         (op),
			.newer_val  ((k == 0) ? sample_value : cell_st[(k == 0) ? 0 : k-1].val),
			.older      (older),
			.older_mode (older_mode),
			.strm_in    (strm_in),
			.occupied   (occupied),
			.best       (best),
			.st         (cell_st[k]),
			.strm       (cell_strm[k]),
			.mode       (cell_mode[k])
		);
	end

	// --- checks -----------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(STORE_DEPTH))
		else $error("fill level beyond store depth");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && set_empty |-> mode_count == '0 && last_result)
		else $error("empty result malformed");

	a_mode_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !set_empty |-> mode_count != '0)
		else $error("mode result with zero count");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN && cell_st[0].head |-> cell_st[0].tally <= best)
		else $error("head tally above best");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN && state_d == S_IDLE |=> out_valid && last_result)
		else $error("search ended without a last result");

endmodule
`default_nettype wire
